// ===== rtl/avs_vid_voltage_ramp_macros.svh =====
// Assertion macros for the voltage ramp sequencer.
// Included by the top level; the macros are empty when SYNTHESIS is defined.
`ifndef AVS_VID_VOLTAGE_RAMP_MACROS_SVH
`define AVS_VID_VOLTAGE_RAMP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AVSVR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define AVSVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define AVSVR_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define AVSVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/avsvr_pkg.sv =====
// Shared types, constants and VID tables for the voltage ramp sequencer.
// No dependencies.
`timescale 1ns / 1ps

package avsvr_pkg;

   localparam int IDX_W        = 6;
   localparam int VID_W        = 14;
   localparam int RB_W         = 16;
   localparam int TABLE_LEN_N  = 41;
   localparam int TOP_INDEX_DEF = 38;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int QDEPTH       = 2;

   localparam logic [IDX_W-1:0] MAX_IDX   = 6'd40;
   localparam logic [IDX_W-1:0] TABLE_LEN = 6'd41;

   // board codes as written through the CSR
   localparam logic [2:0] BOARD_NONE = 3'd4;   // first unsupported code, reset value
   localparam logic       CSR_IDX_BOARD_KIND = 1'b0;

   typedef enum logic [1:0] {
      BOARD_A1 = 2'd0,
      BOARD_A4 = 2'd1,
      BOARD_B  = 2'd2,
      BOARD_C  = 2'd3
   } board_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_SEARCH
   } front_state_type;

   // one ramp job handed from the search to the emitter
   typedef struct packed {
      board_type         kind;
      logic [IDX_W-1:0]  start_idx;
      logic [IDX_W-1:0]  goal_idx;
   } desc_type;

   typedef struct packed {
      logic [6:0] fxd_addr;
      logic [6:0] avs_addr;
      logic [7:0] fxd_cmd;
      logic [7:0] avs_cmd;
      logic [1:0] nbytes;
   } cmd_type;

   localparam logic [VID_W-1:0] TAB_A [TABLE_LEN_N] = '{
      14'h0133,14'h0138,14'h013D,14'h0142,14'h0147,14'h014C,14'h0151,14'h0157,
      14'h015C,14'h0161,14'h0166,14'h016B,14'h0170,14'h0175,14'h017A,14'h0180,
      14'h0185,14'h018A,14'h018F,14'h0194,14'h0199,14'h019E,14'h01A3,14'h01A8,
      14'h01AE,14'h01B3,14'h01B8,14'h01BD,14'h01C2,14'h01C7,14'h01CC,14'h01D1,
      14'h01D7,14'h01DC,14'h01E1,14'h01E6,14'h01EB,14'h01F0,14'h01F5,14'h01FA,
      14'h0200};

   localparam logic [VID_W-1:0] TAB_B [TABLE_LEN_N] = '{
      14'h0027,14'h0029,14'h002B,14'h002E,14'h0030,14'h0032,14'h0034,14'h0036,
      14'h0038,14'h0039,14'h003B,14'h003D,14'h003F,14'h0041,14'h0044,14'h0046,
      14'h0048,14'h004A,14'h004C,14'h004E,14'h0050,14'h0052,14'h0053,14'h0055,
      14'h0057,14'h0059,14'h005C,14'h005E,14'h0060,14'h0062,14'h0064,14'h0066,
      14'h0068,14'h006A,14'h006B,14'h006D,14'h006F,14'h0071,14'h0073,14'h0076,
      14'h0078};

   localparam logic [VID_W-1:0] TAB_CA [TABLE_LEN_N] = '{
      14'h1333,14'h1385,14'h13D7,14'h1428,14'h147A,14'h14CC,14'h151E,14'h1570,
      14'h15C2,14'h1614,14'h1666,14'h16B8,14'h170A,14'h175C,14'h17AE,14'h1800,
      14'h1851,14'h18A3,14'h18F5,14'h1947,14'h1999,14'h19EB,14'h1A3D,14'h1A8F,
      14'h1AE1,14'h1B33,14'h1B85,14'h1BD7,14'h1C28,14'h1C7A,14'h1CCC,14'h1D1E,
      14'h1D70,14'h1DC2,14'h1E14,14'h1E66,14'h1EB8,14'h1F0A,14'h1F5C,14'h1FAE,
      14'h2000};

   localparam logic [VID_W-1:0] TAB_CF [TABLE_LEN_N] = '{
      14'h0999,14'h09C2,14'h09EB,14'h0A14,14'h0A3D,14'h0A66,14'h0A8F,14'h0AB8,
      14'h0AE1,14'h0B0A,14'h0B33,14'h0B5C,14'h0B85,14'h0BAE,14'h0BD7,14'h0C00,
      14'h0C28,14'h0C51,14'h0C7A,14'h0CA3,14'h0CCC,14'h0CF5,14'h0D1E,14'h0D47,
      14'h0D70,14'h0D99,14'h0DC2,14'h0DEB,14'h0E14,14'h0E3D,14'h0E66,14'h0E8F,
      14'h0EB8,14'h0EE1,14'h0F0A,14'h0F33,14'h0F5C,14'h0F85,14'h0FAE,14'h0FD7,
      14'h1000};

   // fixed rail table; also the table the readback is searched in
   function automatic logic [VID_W-1:0] fxd_entry(board_type kind, logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] i;
      logic [VID_W-1:0] v;
      i = (idx > MAX_IDX) ? MAX_IDX : idx;
      case (kind)
         BOARD_B: v = TAB_B[i];
         BOARD_C: v = TAB_CF[i];
         default: v = TAB_A[i];
      endcase
      return v;
   endfunction

   function automatic logic [VID_W-1:0] avs_entry(board_type kind, logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] i;
      logic [VID_W-1:0] v;
      i = (idx > MAX_IDX) ? MAX_IDX : idx;
      case (kind)
         BOARD_B: v = TAB_B[i];
         BOARD_C: v = TAB_CA[i];
         default: v = TAB_A[i];
      endcase
      return v;
   endfunction

   function automatic cmd_type board_cmd(board_type kind);
      cmd_type c;
      case (kind)
         BOARD_A1: c = '{fxd_addr: 7'h58, avs_addr: 7'h57, fxd_cmd: 8'h21,
                         avs_cmd: 8'h21, nbytes: 2'd2};
         BOARD_A4: c = '{fxd_addr: 7'h57, avs_addr: 7'h57, fxd_cmd: 8'h21,
                         avs_cmd: 8'h21, nbytes: 2'd2};
         BOARD_B:  c = '{fxd_addr: 7'h5E, avs_addr: 7'h5E, fxd_cmd: 8'h20,
                         avs_cmd: 8'h21, nbytes: 2'd1};
         BOARD_C:  c = '{fxd_addr: 7'h0E, avs_addr: 7'h0D, fxd_cmd: 8'h21,
                         avs_cmd: 8'h21, nbytes: 2'd2};
         default:  c = '{fxd_addr: 7'h58, avs_addr: 7'h57, fxd_cmd: 8'h21,
                         avs_cmd: 8'h21, nbytes: 2'd2};
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/avs_vid_voltage_ramp.sv =====
// Top level of the AVS voltage ramp sequencer: CSR, search front end, job queue, emitter.
// Depends on avsvr_pkg, avsvr_front, avsvr_queue, avsvr_back and the macros header.
`timescale 1ns / 1ps
`include "avs_vid_voltage_ramp_macros.svh"

// A request word (start high while busy is low) carries a target voltage index and the
// VID read back from the fixed-rail regulator. The front end finds the start index by a
// binary search of the board's fixed-rail table, one table probe per cycle, five or six
// probes in all; busy stays high from the taking of a request until the job is handed to
// the two-entry job queue, and that hand-off waits while the queue is full. The back end
// then drives one command word per cycle, from the start index to the target inclusive
// (a rising ramp also stops at the top index or at the end of the table), with rsp_last
// on the final word. Result words appear on the rsp_ ports for exactly one cycle each,
// marked by rsp_valid; the receiver cannot stall them. Requests may be issued while an
// earlier ramp is still being emitted; they queue up behind it. On an unsupported board
// (board_kind 4..7) a request is taken and dropped with no result word. board_kind sits
// at address 0 and may be changed only while idle.
module avs_vid_voltage_ramp import avsvr_pkg::*; #(
   parameter int TOP_INDEX = TOP_INDEX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [IDX_W-1:0]      req_target_index,
   input  logic [RB_W-1:0]       req_readback_vid,
   // result channel
   output logic                  rsp_valid,
   output logic [IDX_W-1:0]      rsp_step_index,
   output logic [VID_W-1:0]      rsp_fxd_vid,
   output logic [VID_W-1:0]      rsp_avs_vid,
   output logic [6:0]            rsp_fxd_device_addr,
   output logic [6:0]            rsp_avs_device_addr,
   output logic [7:0]            rsp_fxd_command,
   output logic [7:0]            rsp_avs_command,
   output logic [1:0]            rsp_byte_count,
   output logic                  rsp_last,
   // CSR port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [2:0] board_kind_ff, board_kind_in;
   logic       csr_wr;
   logic       csr_hit;

   logic       front_push;
   desc_type   front_desc;
   logic       q_full, q_empty, q_pop;
   desc_type   q_desc;

   // ---------------------------------------------------------------------------
   // CSR: one register, board_kind, word index taken from paddr[2]
   // ---------------------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_hit = paddr[2] == CSR_IDX_BOARD_KIND;
   assign csr_wr  = psel && penable && pwrite && pready && csr_hit;
   assign prdata  = csr_hit ? {{(CSR_DATA_W-3){1'b0}}, board_kind_ff} : '0;

   always_comb begin
      board_kind_in = csr_wr ? pwdata[2:0] : board_kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_kind_ff <= BOARD_NONE;
      end else begin
         board_kind_ff <= board_kind_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Front end: takes the request word, searches the start index
   // ---------------------------------------------------------------------------
   avsvr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .target_index (req_target_index),
      .readback_vid (req_readback_vid),
      .board_kind   (board_kind_ff),
      .push         (front_push),
      .push_data    (front_desc),
      .q_full       (q_full)
   );

   // ---------------------------------------------------------------------------
   // Job queue: lets the search run ahead of a long ramp
   // ---------------------------------------------------------------------------
   avsvr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_desc),
      .empty     (q_empty)
   );

   // ---------------------------------------------------------------------------
   // Emitter: one command word per cycle until the ramp ends
   // ---------------------------------------------------------------------------
   avsvr_back #(
      .TOP_INDEX (TOP_INDEX)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .pop                 (q_pop),
      .pop_data            (q_desc),
      .rsp_valid           (rsp_valid),
      .rsp_step_index      (rsp_step_index),
      .rsp_fxd_vid         (rsp_fxd_vid),
      .rsp_avs_vid         (rsp_avs_vid),
      .rsp_fxd_device_addr (rsp_fxd_device_addr),
      .rsp_avs_device_addr (rsp_avs_device_addr),
      .rsp_fxd_command     (rsp_fxd_command),
      .rsp_avs_command     (rsp_avs_command),
      .rsp_byte_count      (rsp_byte_count),
      .rsp_last            (rsp_last)
   );

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
   // the search never hands a job to a full queue
   `AVSVR_ASSERT_NOW(a_no_push_when_full, clock, reset, front_push, !q_full,
      "push into full queue")
   // a ramp word without last is always followed by another word
   `AVSVR_ASSERT_NEXT(a_ramp_unbroken, clock, reset, rsp_valid && !rsp_last, rsp_valid,
      "ramp broken")
   // consecutive words of one ramp move by exactly one index
   `AVSVR_ASSERT_NEXT(a_ramp_step_one, clock, reset, rsp_valid && !rsp_last,
      (rsp_step_index == $past(rsp_step_index) + 6'd1) ||
      (rsp_step_index == $past(rsp_step_index) - 6'd1), "ramp step not one index")

endmodule

// ===== rtl/avsvr_front.sv =====
// Front end: takes a request, binary-searches the start index in the board's table.
// Depends on avsvr_pkg.
`timescale 1ns / 1ps

module avsvr_front import avsvr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [IDX_W-1:0] target_index,
   input  logic [RB_W-1:0]  readback_vid,
   input  logic [2:0]       board_kind,
   output logic             push,
   output desc_type         push_data,
   input  logic             q_full
);

   front_state_type  state_ff, state_in;
   logic [IDX_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0] target_ff, target_in;
   logic [RB_W-1:0]  vid_ff, vid_in;
   board_type        kind_ff, kind_in;

   logic [IDX_W:0]   mid_sum;
   logic [IDX_W-1:0] mid;
   logic [VID_W-1:0] probe;
   logic             hit, found;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IDX_W:1];
   assign probe   = fxd_entry(kind_ff, mid);
   assign hit     = {{(RB_W-VID_W){1'b0}}, probe} >= vid_ff;
   assign found   = lo_ff >= hi_ff;
   assign busy    = state_ff != FRONT_IDLE;

   // lower bound over 41 entries; readback past the end clamps to the last entry, MAX_IDX
   assign push_data.kind      = kind_ff;
   assign push_data.goal_idx  = target_ff;
   assign push_data.start_idx = (lo_ff > MAX_IDX) ? MAX_IDX : lo_ff;

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      target_in = target_ff;
      vid_in    = vid_ff;
      kind_in   = kind_ff;
      push      = 1'b0;
      case (state_ff)
         FRONT_IDLE: begin
            // unsupported boards are taken and dropped
            if (start && (board_kind < BOARD_NONE)) begin
               state_in  = FRONT_SEARCH;
               lo_in     = '0;
               hi_in     = TABLE_LEN;
               target_in = target_index;
               kind_in   = board_type'(board_kind[1:0]);
               if (board_type'(board_kind[1:0]) == BOARD_B) begin
                  vid_in = {{(RB_W-8){1'b0}}, readback_vid[7:0]};
               end else begin
                  vid_in = readback_vid;
               end
            end
         end
         FRONT_SEARCH: begin
            if (found) begin
               if (!q_full) begin
                  push     = 1'b1;
                  state_in = FRONT_IDLE;
               end
            end else if (hit) begin
               hi_in = mid;
            end else begin
               lo_in = mid + 6'd1;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      target_ff <= target_in;
      vid_ff    <= vid_in;
      kind_ff   <= kind_in;
   end

endmodule

// ===== rtl/avsvr_queue.sv =====
// Two-entry job queue between search and emitter.
// Depends on avsvr_pkg.
`timescale 1ns / 1ps

module avsvr_queue import avsvr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   output logic     full,
   input  logic     pop,
   output desc_type pop_data,
   output logic     empty
);

   desc_type   slot_ff [QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = count_ff == 2'(QDEPTH);
   assign empty    = count_ff == 2'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/avsvr_back.sv =====
// Back end: walks one ramp job index by index and drives one command word per cycle.
// Depends on avsvr_pkg.
`timescale 1ns / 1ps

module avsvr_back import avsvr_pkg::*; #(
   parameter int TOP_INDEX = TOP_INDEX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   output logic             pop,
   input  desc_type         pop_data,
   output logic             rsp_valid,
   output logic [IDX_W-1:0] rsp_step_index,
   output logic [VID_W-1:0] rsp_fxd_vid,
   output logic [VID_W-1:0] rsp_avs_vid,
   output logic [6:0]       rsp_fxd_device_addr,
   output logic [6:0]       rsp_avs_device_addr,
   output logic [7:0]       rsp_fxd_command,
   output logic [7:0]       rsp_avs_command,
   output logic [1:0]       rsp_byte_count,
   output logic             rsp_last
);

   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(TOP_INDEX);

   logic             active_ff, active_in;
   logic             up_ff, up_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] target_ff, target_in;
   board_type        kind_ff, kind_in;
   logic             fin;
   cmd_type          cmd;

   logic             valid_ff;
   logic [IDX_W-1:0] step_ff;
   logic [VID_W-1:0] fxd_vid_ff, avs_vid_ff;
   cmd_type          cmd_ff;
   logic             last_ff;

   assign cmd = board_cmd(kind_ff);
   // a rising ramp also stops at the top index or at the end of the table
   assign fin = up_ff ? ((idx_ff == target_ff) || (idx_ff == TOP_IDX) || (idx_ff >= MAX_IDX))
                      : (idx_ff == target_ff);
   assign pop = !active_ff && !q_empty;

   always_comb begin
      active_in = active_ff;
      up_in     = up_ff;
      idx_in    = idx_ff;
      target_in = target_ff;
      kind_in   = kind_ff;
      if (active_ff) begin
         active_in = !fin;
         idx_in    = up_ff ? idx_ff + 6'd1 : idx_ff - 6'd1;
      end else if (!q_empty) begin
         active_in = 1'b1;
         idx_in    = pop_data.start_idx;
         target_in = pop_data.goal_idx;
         kind_in   = pop_data.kind;
         up_in     = pop_data.start_idx < pop_data.goal_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      up_ff      <= up_in;
      idx_ff     <= idx_in;
      target_ff  <= target_in;
      kind_ff    <= kind_in;
      step_ff    <= idx_ff;
      fxd_vid_ff <= fxd_entry(kind_ff, idx_ff);
      avs_vid_ff <= avs_entry(kind_ff, idx_ff);
      cmd_ff     <= cmd;
      last_ff    <= fin;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_step_index      = step_ff;
   assign rsp_fxd_vid         = fxd_vid_ff;
   assign rsp_avs_vid         = avs_vid_ff;
   assign rsp_fxd_device_addr = cmd_ff.fxd_addr;
   assign rsp_avs_device_addr = cmd_ff.avs_addr;
   assign rsp_fxd_command     = cmd_ff.fxd_cmd;
   assign rsp_avs_command     = cmd_ff.avs_cmd;
   assign rsp_byte_count      = cmd_ff.nbytes;
   assign rsp_last            = last_ff;

endmodule
